>>> src/smcs_pkg.sv
// Shared widths and constants for the softmax categorical sampler.
package smcs_pkg;

    localparam int LOGIT_W    = 12;  // Q4.8 signed logit
    localparam int DRAW_W     = 16;  // uniform draw, value/65536
    localparam int IDX_W      = 6;   // reported index width
    localparam int EXP_W      = 24;  // Q12.12 exponential
    localparam int SUM_W      = 30;  // running sum of exponentials
    localparam int MAG_W      = 12;  // |logit|, up to 2048
    localparam int FRAC_BITS  = 40;  // series fraction bits
    localparam int SER_W      = 53;  // series sum, below 2^52
    localparam int TERM_W     = 52;  // one series term
    localparam int PROD_W     = TERM_W + MAG_W;
    localparam int DVD_W      = PROD_W - 8;       // product / 256
    localparam int DIV_STEP   = 4;                // quotient bits per cycle
    localparam int DIV_CYCLES = DVD_W / DIV_STEP;
    localparam int N_W        = 7;                // series index, 1..80
    localparam int N_LAST     = 80;
    localparam int RQ_W       = 13;               // reciprocal quotient bits
    localparam int RREM_W     = SER_W + 1;        // reciprocal remainder
    localparam int THR_W      = DRAW_W + SUM_W;
    localparam int REM_W      = 32;               // signed walk remainder

    localparam logic [SER_W-1:0]  SERIES_ONE = SER_W'(1) << FRAC_BITS;
    localparam logic [SER_W-1:0]  ROUND_HALF = SER_W'(1) << (FRAC_BITS - 13);
    localparam logic [EXP_W-1:0]  EXP_MAX    = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX    = '1;

endpackage

>>> src/softmax_categorical_sampler_unit.sv
// Softmax categorical sampler: exp series, running sum and sampling walk.
//
// Usage
//   Input channel (i_in_valid / o_in_ready): one logit per item, signed Q4.8,
//   with i_last set on the final element of a vector; i_random_draw is used
//   only on that final item. Output channel (o_out_valid / i_out_ready): one
//   item per vector, the sampled index (mod 64) and the overflow flag that
//   tells elements beyond MAX_LEN were dropped.
//   Each item's exponential is built by one shared series datapath: a
//   multiply by |logit| then a 4-bit-per-cycle divide by the term number for
//   every series term. Small logits end after a few terms, logits near +-8
//   run about 41 term passes. Negative logits add a restoring division for
//   the reciprocal. Rounding and storing follow, and the block returns to
//   idle before the next item; a final item adds a threshold step and then
//   walks the stored elements.
//   The block takes one item at a time: o_in_ready is high only in idle.
//   A finished result sits in the output register while the next vector is
//   loaded; a stalled receiver only holds the block at the end of the walk.
//   Reset (synchronous, active low) clears the sum, count, drop flag and the
//   output valid; stored exponentials need no clearing.
module softmax_categorical_sampler_unit #(
    parameter int MAX_LEN = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [smcs_pkg::LOGIT_W-1:0] i_logit,
    input  logic [smcs_pkg::DRAW_W-1:0]       i_random_draw,
    input  logic                              i_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [smcs_pkg::IDX_W-1:0]        o_chosen_index,
    output logic                              o_overflow
);
    import smcs_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIV, S_ACC, S_FIN, S_RECIP, S_STORE, S_THR, S_WALK
    } t_state;

    t_state               r_state;
    logic [MAG_W-1:0]     r_mag;
    logic                 r_neg;
    logic [DRAW_W-1:0]    r_draw;
    logic                 r_last;
    logic [TERM_W-1:0]    r_term;
    logic [SER_W-1:0]     r_esum;
    logic [N_W-1:0]       r_n;
    logic [DVD_W-1:0]     r_dvd;
    logic [N_W-1:0]       r_drem;
    logic [3:0]           r_dig;
    logic [RREM_W-1:0]    r_rrem;
    logic [RREM_W-1:0]    r_rdiv;
    logic [RQ_W-1:0]      r_rq;
    logic [3:0]           r_rcnt;
    logic [EXP_W-1:0]     r_exp;
    logic [SUM_W-1:0]     r_run_sum;
    logic [CW-1:0]        r_count;
    logic                 r_dropped;
    logic signed [REM_W-1:0] r_rem;
    logic [AW-1:0]        r_idx;
    logic [EXP_W-1:0]     r_rd_data;
    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_chosen;
    logic                 r_overflow;

    logic [EXP_W-1:0]     mem [MAX_LEN];

    // next-value signals
    logic [MAG_W-1:0]     n_mag;
    logic [PROD_W-1:0]    n_prod;
    logic [DVD_W-1:0]     n_dvd;
    logic [N_W-1:0]       n_drem;
    logic [RREM_W:0]      n_rsh;
    logic                 n_rge;
    logic [RREM_W-1:0]    n_rrem;
    logic [SER_W-1:0]     n_rounded;
    logic [EXP_W-1:0]     n_pos_exp;
    logic [SUM_W:0]       n_sum_wide;
    logic [SUM_W-1:0]     n_sum;
    logic [THR_W-1:0]     n_thr;
    logic signed [REM_W-1:0] n_diff;
    logic                 n_end;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 out_free;
    logic                 res_fire;

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_chosen_index = r_chosen;
    assign o_overflow     = r_overflow;
    assign out_free       = !r_out_valid || i_out_ready;

    // |logit|; the most negative code maps to 2048
    assign n_mag  = i_logit[LOGIT_W-1] ? MAG_W'(13'h1000 - {1'b0, i_logit}) : i_logit;
    assign n_prod = PROD_W'(r_term) * PROD_W'(r_mag);

    // divide by term number, DIV_STEP quotient bits per cycle
    always_comb begin
        logic [N_W-1:0]   d_rem;
        logic [DVD_W-1:0] d_dvd;
        logic [N_W:0]     d_sh;
        d_rem = r_drem;
        d_dvd = r_dvd;
        for (int k = 0; k < DIV_STEP; k++) begin
            d_sh = {d_rem, d_dvd[DVD_W-1]};
            if (d_sh >= {1'b0, r_n}) begin
                d_rem = N_W'(d_sh - {1'b0, r_n});
                d_dvd = {d_dvd[DVD_W-2:0], 1'b1};
            end else begin
                d_rem = d_sh[N_W-1:0];
                d_dvd = {d_dvd[DVD_W-2:0], 1'b0};
            end
        end
        n_drem = d_rem;
        n_dvd  = d_dvd;
    end

    // reciprocal: restoring divide of 2^53 + sum by 2 * sum
    assign n_rsh  = {r_rrem, r_rq[RQ_W-1]};
    assign n_rge  = (n_rsh >= {1'b0, r_rdiv});
    assign n_rrem = n_rge ? RREM_W'(n_rsh - {1'b0, r_rdiv}) : n_rsh[RREM_W-1:0];

    // positive rounding: (sum + 2^27) >> 28, saturated
    assign n_rounded = (r_esum + ROUND_HALF) >> (FRAC_BITS - 12);
    assign n_pos_exp = (n_rounded > SER_W'(EXP_MAX)) ? EXP_MAX : n_rounded[EXP_W-1:0];

    assign n_sum_wide = {1'b0, r_run_sum} + (SUM_W + 1)'(r_exp);
    assign n_sum      = (n_sum_wide > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX
                                                             : n_sum_wide[SUM_W-1:0];

    assign n_thr  = THR_W'(r_draw) * THR_W'(r_run_sum);
    assign n_diff = r_rem - $signed({{(REM_W - EXP_W){1'b0}}, r_rd_data});
    // the last stored index is also the fallback answer
    assign n_end  = (n_diff <= 0) || (CW'(r_idx) == CW'(r_count - 1'b1));

    // walk done and the output register can take the result
    assign res_fire = (r_state == S_WALK) && n_end && out_free;

    assign rd_en   = (r_state == S_THR) || ((r_state == S_WALK) && !n_end);
    assign rd_addr = (r_state == S_THR) ? '0 : AW'(r_idx + 1'b1);

    always_ff @(posedge i_clk) begin
        if ((r_state == S_STORE) && (r_count < CW'(MAX_LEN))) begin
            mem[AW'(r_count)] <= r_exp;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_run_sum   <= '0;
            r_count     <= '0;
            r_dropped   <= 1'b0;
        end else begin
            if (res_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mag   <= n_mag;
                        r_neg   <= i_logit[LOGIT_W-1];
                        r_draw  <= i_random_draw;
                        r_last  <= i_last;
                        r_term  <= TERM_W'(SERIES_ONE);
                        r_esum  <= SERIES_ONE;
                        r_n     <= N_W'(1);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_dvd   <= DVD_W'(n_prod >> 8);
                    r_drem  <= '0;
                    r_dig   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dvd  <= n_dvd;
                    r_drem <= n_drem;
                    r_dig  <= r_dig + 1'b1;
                    if (r_dig == 4'(DIV_CYCLES - 1)) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_dvd == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_term <= r_dvd[TERM_W-1:0];
                        r_esum <= r_esum + SER_W'(r_dvd);
                        if (r_n == N_W'(N_LAST)) begin
                            r_state <= S_FIN;
                        end else begin
                            r_n     <= r_n + 1'b1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_FIN: begin
                    if (r_neg) begin
                        r_rrem  <= RREM_W'({1'b1, r_esum[SER_W-1:RQ_W]});
                        r_rq    <= r_esum[RQ_W-1:0];
                        r_rdiv  <= {r_esum, 1'b0};
                        r_rcnt  <= '0;
                        r_state <= S_RECIP;
                    end else begin
                        r_exp   <= n_pos_exp;
                        r_state <= S_STORE;
                    end
                end
                S_RECIP: begin
                    r_rrem <= n_rrem;
                    r_rq   <= {r_rq[RQ_W-2:0], n_rge};
                    r_rcnt <= r_rcnt + 1'b1;
                    if (r_rcnt == 4'(RQ_W - 1)) begin
                        r_exp   <= EXP_W'({r_rq[RQ_W-2:0], n_rge});
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    if (r_count < CW'(MAX_LEN)) begin
                        r_run_sum <= n_sum;
                        r_count   <= r_count + 1'b1;
                    end else begin
                        r_dropped <= 1'b1;
                    end
                    r_state <= r_last ? S_THR : S_IDLE;
                end
                S_THR: begin
                    r_rem   <= $signed({{(REM_W - SUM_W){1'b0}}, n_thr[THR_W-1:DRAW_W]});
                    r_idx   <= '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (!n_end) begin
                        r_rem <= n_diff;
                        r_idx <= r_idx + 1'b1;
                    end else if (out_free) begin
                        r_chosen    <= IDX_W'(r_idx);
                        r_overflow  <= r_dropped;
                        r_run_sum   <= '0;
                        r_count     <= '0;
                        r_dropped   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // stored element count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_LEN))
        else $error("element count above capacity");

    // series term number stays in range while dividing
    a_term_no: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_n != '0) && (r_n <= N_W'(N_LAST))))
        else $error("series term number out of range");

    // restoring divide keeps its remainder below the divisor
    a_recip_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RECIP) |-> (r_rrem < r_rdiv))
        else $error("reciprocal remainder not reduced");

    // walk only continues while the threshold remainder is not used up
    a_walk_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_rem >= 0))
        else $error("walk remainder negative");

    // a result appears only at the end of a walk, with the vector cleared
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_WALK) && (r_count == '0))
        else $error("result produced outside the walk");

endmodule
